### design/sat_pkg.sv
// types and constants shared by the stream admission table files
package sat_pkg;

  localparam int KeyW    = 32;
  localparam int ParamW  = 25;

  localparam logic [1:0] ST_ABSENT      = 2'd0;
  localparam logic [1:0] ST_LISTEN      = 2'd1;
  localparam logic [1:0] ST_ACCEPTED    = 2'd2;
  localparam logic [1:0] ST_ESTABLISHED = 2'd3;

  localparam logic [1:0] INFO_OPENED = 2'd0;
  localparam logic [1:0] INFO_CLOSED = 2'd1;
  localparam logic [1:0] INFO_REJECT = 2'd2;

  localparam logic [1:0] SME_CONNECT = 2'd0;
  localparam logic [1:0] SME_LISTEN  = 2'd1;
  localparam logic [1:0] SME_CLOSED  = 2'd2;
  localparam logic [1:0] SME_RESEND  = 2'd3;

  localparam logic CMD_SME    = 1'b0;
  localparam logic CMD_CHANGE = 1'b1;

  localparam logic [1:0] CHG_ESTABLISH = 2'd0;
  localparam logic [1:0] CHG_REJECT    = 2'd1;
  localparam logic [1:0] CHG_CLOSE     = 2'd2;

  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_ESTAB  = 2'd2;
  localparam logic [1:0] OP_INSERT = 2'd3;

  typedef struct packed {
    logic             cmd;
    logic [KeyW-1:0]  stream_key;
    logic             is_server;
    logic [KeyW-1:0]  server_key;
    logic [1:0]       sme_type;
    logic [1:0]       change_kind;
    logic [2:0]       redundancy;
    logic [3:0]       period;
    logic [15:0]      payload_size;
    logic [1:0]       direction;
  } in_word_t;

  typedef struct packed {
    logic             info_valid;
    logic [1:0]       info_type;
    logic [KeyW-1:0]  info_key;
    logic             resend;
    logic             added;
    logic             removed;
    logic             table_full;
    logic [1:0]       entry_status;
  } out_word_t;

  // lookup broadcast to every cell
  typedef struct packed {
    logic            load;
    logic [KeyW-1:0] key;
    logic            srv;
    logic [KeyW-1:0] skey;
  } query_t;

  // update broadcast to every cell
  typedef struct packed {
    logic [1:0]        op;
    logic [KeyW-1:0]   key;
    logic [1:0]        status;
    logic [ParamW-1:0] params;
  } update_t;

  // what a cell reports back
  typedef struct packed {
    logic              e_hit;
    logic              s_hit;
    logic              claim;
    logic [1:0]        status;
    logic [ParamW-1:0] params;
  } cell_rsp_t;

endpackage

### design/sat_if.sv
// valid/ready channel carrying one word of a given type
interface sat_if #(parameter type word_t = logic) (input logic clk);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/sat_cell.sv
// one table entry with its match logic and free-slot chain link
module sat_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sat_pkg::query_t     query,
  input  sat_pkg::update_t    upd,
  input  logic                free_in,
  output logic                free_out,
  output sat_pkg::cell_rsp_t  rsp
);
  import sat_pkg::*;

  logic              valid_r, valid_nxt;
  logic [KeyW-1:0]   key_r;
  logic [1:0]        status_r;
  logic [ParamW-1:0] params_r;
  logic              e_hit_r, s_hit_r, claim_r;
  logic              e_hit, s_hit;

  // free chain: first empty cell after all full ones claims the slot
  assign free_out = free_in | ~valid_r;

  assign e_hit = valid_r && (key_r == query.key) && ((status_r == ST_LISTEN) == query.srv);
  assign s_hit = valid_r && (key_r == query.skey) && (status_r == ST_LISTEN);

  // valid bit update
  always_comb begin
    valid_nxt = valid_r;
    if (upd.op == OP_CLEAR && e_hit_r) begin
      valid_nxt = 1'b0;
    end else if (upd.op == OP_INSERT && claim_r) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      e_hit_r <= 1'b0;
      s_hit_r <= 1'b0;
      claim_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (query.load) begin
        e_hit_r <= e_hit;
        s_hit_r <= s_hit;
        claim_r <= ~valid_r & ~free_in;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (upd.op == OP_INSERT && claim_r) begin
      key_r    <= upd.key;
      status_r <= upd.status;
      params_r <= upd.params;
    end else if (upd.op == OP_ESTAB && e_hit_r) begin
      status_r <= ST_ESTABLISHED;
    end
  end

  assign rsp.e_hit  = e_hit_r;
  assign rsp.s_hit  = s_hit_r;
  assign rsp.claim  = claim_r;
  assign rsp.status = status_r;
  assign rsp.params = params_r;
endmodule

### design/stream_admission_table.sv
// top level of the stream admission table
// Stream and server admission table built as a row of TABLE_DEPTH entry cells. Each
// word passes from acceptance to a valid result through a look step, where the keys are
// broadcast and every cell compares and registers its hits and its free-slot claim, and
// a decide step that updates the cells; the result then sits in the output register.
// The next word is accepted while that result still waits; its decide cycle stalls only
// while the previous result is still held. Lookups match on key and kind
// (server or stream); inserts go to the lowest free cell, found by a chain through the row.
module stream_admission_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  sat_if.sink   in_ch,
  sat_if.source out_ch
);
  import sat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  in_word_t    word_r;
  out_word_t   out_r, res;
  logic        out_valid_r, out_valid_nxt;
  query_t      query;
  update_t     upd;
  cell_rsp_t   rsp [TABLE_DEPTH];
  logic [TABLE_DEPTH:0] chain;

  logic              e_any, s_any, f_any;
  logic [1:0]        e_status;
  logic [ParamW-1:0] s_params;
  logic [2:0]        s_red, n_red;
  logic [3:0]        s_per, n_per;
  logic [15:0]       s_pay, n_pay;
  logic [1:0]        s_dir;

  assign in_ch.ready = (state_r == S_IDLE);

  // query broadcast while in the look state
  assign query.load = (state_r == S_LOOK);
  assign query.key  = word_r.stream_key;
  assign query.srv  = word_r.is_server;
  assign query.skey = word_r.server_key;

  // row of entry cells
  assign chain[0] = 1'b0;
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sat_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .query    (query),
      .upd      (upd),
      .free_in  (chain[i]),
      .free_out (chain[i+1]),
      .rsp      (rsp[i])
    );
  end

  // gather hit data; keys are unique per kind so at most one cell hits
  always_comb begin
    e_any    = 1'b0;
    s_any    = 1'b0;
    f_any    = 1'b0;
    e_status = ST_ABSENT;
    s_params = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      e_any    = e_any | rsp[i].e_hit;
      s_any    = s_any | rsp[i].s_hit;
      f_any    = f_any | rsp[i].claim;
      e_status = e_status | (rsp[i].status & {2{rsp[i].e_hit}});
      s_params = s_params | (rsp[i].params & {ParamW{rsp[i].s_hit}});
    end
  end

  assign s_red = s_params[2:0];
  assign s_per = s_params[6:3];
  assign s_pay = s_params[22:7];
  assign s_dir = s_params[24:23];
  assign n_red = (word_r.redundancy < s_red) ? word_r.redundancy : s_red;
  assign n_per = (word_r.period > s_per) ? word_r.period : s_per;
  assign n_pay = (word_r.payload_size < s_pay) ? word_r.payload_size : s_pay;

  // decision on the registered lookup
  always_comb begin
    res        = '0;
    upd.op     = OP_NONE;
    upd.key    = word_r.stream_key;
    upd.status = word_r.is_server ? ST_LISTEN : ST_ACCEPTED;
    upd.params = {word_r.direction, word_r.payload_size, word_r.period, word_r.redundancy};
    if (!word_r.is_server) begin
      upd.params = {word_r.direction, n_pay, n_per, n_red};
    end
    if (word_r.cmd == CMD_SME) begin
      if (word_r.sme_type == SME_RESEND) begin
        res.resend = 1'b1;
      end else if (e_any && !word_r.is_server) begin
        if (word_r.sme_type == SME_CLOSED) begin
          upd.op      = OP_CLEAR;
          res.removed = 1'b1;
        end else if (word_r.sme_type == SME_CONNECT && e_status == ST_ESTABLISHED) begin
          res.resend = 1'b1;
        end
      end else if (e_any) begin
        if (word_r.sme_type == SME_CLOSED) begin
          upd.op         = OP_CLEAR;
          res.info_valid = 1'b1;
          res.info_type  = INFO_CLOSED;
        end else if (word_r.sme_type == SME_LISTEN) begin
          res.info_valid = 1'b1;
          res.info_type  = INFO_OPENED;
        end
      end else if (!word_r.is_server) begin
        if (word_r.sme_type == SME_CLOSED) begin
          res.resend = 1'b1;
        end else if (word_r.sme_type == SME_CONNECT) begin
          if (!s_any || s_dir != word_r.direction) begin
            res.info_valid = 1'b1;
            res.info_type  = INFO_REJECT;
          end else if (!f_any) begin
            res.table_full = 1'b1;
          end else begin
            upd.op    = OP_INSERT;
            res.added = 1'b1;
          end
        end
      end else begin
        if (word_r.sme_type == SME_LISTEN) begin
          if (!f_any) begin
            res.table_full = 1'b1;
          end else begin
            upd.op         = OP_INSERT;
            res.info_valid = 1'b1;
            res.info_type  = INFO_OPENED;
          end
        end else if (word_r.sme_type == SME_CLOSED) begin
          res.info_valid = 1'b1;
          res.info_type  = INFO_CLOSED;
        end
      end
    end else if (!word_r.is_server && e_any) begin
      case (word_r.change_kind)
        CHG_ESTABLISH: begin
          if (e_status == ST_ACCEPTED) upd.op = OP_ESTAB;
        end
        CHG_REJECT: begin
          if (e_status == ST_ACCEPTED) begin
            upd.op         = OP_CLEAR;
            res.info_valid = 1'b1;
            res.info_type  = INFO_REJECT;
          end
        end
        CHG_CLOSE: begin
          if (e_status == ST_ESTABLISHED) upd.op = OP_CLEAR;
        end
        default: ;
      endcase
    end
    if (res.info_valid) res.info_key = word_r.stream_key;
    // status of the named entry after the update
    case (upd.op)
      OP_CLEAR:  res.entry_status = ST_ABSENT;
      OP_ESTAB:  res.entry_status = ST_ESTABLISHED;
      OP_INSERT: res.entry_status = upd.status;
      default:   res.entry_status = e_any ? e_status : ST_ABSENT;
    endcase
    if (state_r != S_DEC || (out_valid_r && !out_ch.ready)) begin
      upd.op = OP_NONE;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_DEC;
      S_DEC: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) word_r <= in_ch.data;
    if (state_r == S_DEC && (!out_valid_r || out_ch.ready)) out_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
endmodule

### design/sat_checker.sv
// port checker for the stream admission table and its bind
module sat_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input sat_pkg::out_word_t out_data
);
  import sat_pkg::*;

  // a waiting word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  // one word in flight: no accept right after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a new result follows an accepted word
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result without accepted word");

  // unused info fields are zero and flags exclusive
  a_info_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.info_valid || (out_data.info_type == 2'd0 &&
      out_data.info_key == '0)) && !(out_data.added && out_data.removed))
    else $error("bad result fields");
endmodule

bind stream_admission_table sat_checker u_sat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
